// File: rtl/sfbp_pkg.sv
// ----------------------------------------------------------------------------
// sfbp_pkg
// Shared constants and types of the framed byte parser: command, status,
// error and register codes, frame layout and the result record.
// ----------------------------------------------------------------------------
package sfbp_pkg;

  // Default payload buffer depth (bytes per bank)
  localparam int DEF_PAYLOAD_DEPTH = 255;

  // Request commands
  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Feed status codes
  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_DELIVERED = 2'd1;
  localparam logic [1:0] ST_ERROR     = 2'd2;

  // Error kinds
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_VERSION  = 2'd1;
  localparam logic [1:0] ERR_LENGTH   = 2'd2;
  localparam logic [1:0] ERR_CHECKSUM = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_VERSION = 2'd1;
  localparam logic [1:0] CFG_MAXLEN  = 2'd2;

  // Frame layout: header byte positions, header size, header plus checksum
  localparam logic [8:0] POS_MAGIC   = 9'd0;
  localparam logic [8:0] POS_VERSION = 9'd1;
  localparam logic [8:0] POS_TYPE    = 9'd2;
  localparam logic [8:0] POS_LENGTH  = 9'd3;
  localparam logic [8:0] HDR_LEN     = 9'd4;
  localparam logic [8:0] FRAME_EXTRA = 9'd5;

  // Reset value of the max payload register
  localparam logic [7:0] MAXLEN_RST = 8'd255;

  // Result record carried through the pipeline
  typedef struct packed {
    logic [1:0] feed_status;
    logic [1:0] error_kind;
    logic [7:0] packet_type;
    logic [7:0] packet_length;
    logic       rd_en;
  } result_t;

endpackage

// File: rtl/sum8_framed_byte_parser.sv
// ----------------------------------------------------------------------------
// sum8_framed_byte_parser
// Parses magic/version/type/length/payload/sum8 frames one byte per request
// and serves reads of the last delivered payload from a double-buffered RAM.
// ----------------------------------------------------------------------------
// One request is accepted per clock cycle while the result channel does not
// stall; each result is held in stage one, beside the payload RAM's registered
// read port, and then in the output register. The payload RAM has one
// write port used by feed requests and one read port used by read requests,
// so both kinds stream at full rate. The payload RAM powers up undefined and
// needs no clearing pass: only bytes of a delivered frame are ever read.
// Program magic_byte, version_byte and max_payload while no request is in
// flight.
module sum8_framed_byte_parser #(
  parameter int PAYLOAD_DEPTH = sfbp_pkg::DEF_PAYLOAD_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration write port
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_read_index,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_feed_status,
  output logic [1:0] out_error_kind,
  output logic [7:0] out_packet_type,
  output logic [7:0] out_packet_length,
  output logic [7:0] out_read_data
);
  import sfbp_pkg::*;

  localparam int         MEM_DEPTH = 2 * PAYLOAD_DEPTH;
  localparam int         AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [7:0] DEPTH8    = 8'(PAYLOAD_DEPTH);

  // configuration registers
  logic [7:0] magic_r, version_r, maxlen_r;

  // parser state
  logic [8:0] pos_r, pos_nxt;
  logic [8:0] exp_r, exp_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] ftype_r, ftype_nxt;
  logic [7:0] flen_r, flen_nxt;
  logic       dbank_r, dbank_nxt;
  logic [7:0] dtype_r, dtype_nxt;
  logic [7:0] dlen_r, dlen_nxt;
  logic [1:0] err_r, err_nxt;
  logic [1:0] status;

  // pipeline
  logic    s1_vld_r, out_vld_r;
  result_t s1_r, out_r, s1_nxt;
  logic    s1_adv, in_fire, out_load;
  logic [7:0] mem_q_r, out_rd_r;

  // payload RAM
  logic [7:0]    mem [MEM_DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    wr_idx, limit;
  logic [9:0]    pos_inc;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= '0;
      version_r <= '0;
      maxlen_r  <= MAXLEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAGIC:   magic_r   <= cfg_wdata;
        CFG_VERSION: version_r <= cfg_wdata;
        CFG_MAXLEN:  maxlen_r  <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // handshake
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign out_load = s1_adv;

  // frame parser next state
  assign limit   = (maxlen_r < DEPTH8) ? maxlen_r : DEPTH8;
  assign pos_inc = {1'b0, pos_r} + 10'd1;
  assign wr_idx  = 8'(pos_r - HDR_LEN);

  always_comb begin
    pos_nxt   = pos_r;
    exp_nxt   = exp_r;
    sum_nxt   = sum_r;
    ftype_nxt = ftype_r;
    flen_nxt  = flen_r;
    dbank_nxt = dbank_r;
    dtype_nxt = dtype_r;
    dlen_nxt  = dlen_r;
    err_nxt   = err_r;
    status    = ST_NONE;
    mem_we    = 1'b0;
    if (in_cmd == CMD_FEED) begin
      case (pos_r)
        POS_MAGIC: begin
          if (in_data_byte == magic_r) begin
            sum_nxt = in_data_byte;
            pos_nxt = POS_VERSION;
          end
        end
        POS_VERSION: begin
          if (in_data_byte != version_r) begin
            pos_nxt = POS_MAGIC;
            exp_nxt = HDR_LEN;
            sum_nxt = '0;
            err_nxt = ERR_VERSION;
            status  = ST_ERROR;
          end else begin
            sum_nxt = sum_r + in_data_byte;
            pos_nxt = POS_TYPE;
          end
        end
        POS_TYPE: begin
          ftype_nxt = in_data_byte;
          sum_nxt   = sum_r + in_data_byte;
          pos_nxt   = POS_LENGTH;
        end
        POS_LENGTH: begin
          if (in_data_byte > limit) begin
            pos_nxt = POS_MAGIC;
            exp_nxt = HDR_LEN;
            sum_nxt = '0;
            err_nxt = ERR_LENGTH;
            status  = ST_ERROR;
          end else begin
            flen_nxt = in_data_byte;
            exp_nxt  = {1'b0, in_data_byte} + FRAME_EXTRA;
            sum_nxt  = sum_r + in_data_byte;
            pos_nxt  = HDR_LEN;
          end
        end
        default: begin
          if (pos_inc >= {1'b0, exp_r}) begin
            // checksum byte closes the frame
            pos_nxt = POS_MAGIC;
            exp_nxt = HDR_LEN;
            sum_nxt = '0;
            if (sum_r != in_data_byte) begin
              err_nxt = ERR_CHECKSUM;
              status  = ST_ERROR;
            end else begin
              dbank_nxt = ~dbank_r;
              dtype_nxt = ftype_r;
              dlen_nxt  = flen_r;
              err_nxt   = ERR_NONE;
              status    = ST_DELIVERED;
            end
          end else begin
            // payload byte into the back bank
            mem_we  = (wr_idx < DEPTH8);
            sum_nxt = sum_r + in_data_byte;
            pos_nxt = pos_inc[8:0];
          end
        end
      endcase
    end
  end

  // RAM addressing: back bank for writes, front bank for reads
  assign mem_waddr = AW'(wr_idx) + (~dbank_r ? AW'(PAYLOAD_DEPTH) : AW'(0));
  assign mem_raddr = AW'(in_read_index) + (dbank_r ? AW'(PAYLOAD_DEPTH) : AW'(0));
  assign mem_re    = (in_cmd == CMD_READ) && (in_read_index < dlen_r) &&
                     (in_read_index < DEPTH8);

  always_ff @(posedge clk) begin
    if (in_fire && mem_we) begin
      mem[mem_waddr] <= in_data_byte;
    end
    if (in_fire && mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_MAGIC;
      exp_r   <= HDR_LEN;
      sum_r   <= '0;
      ftype_r <= '0;
      flen_r  <= '0;
      dbank_r <= 1'b0;
      dtype_r <= '0;
      dlen_r  <= '0;
      err_r   <= ERR_NONE;
    end else if (in_fire) begin
      pos_r   <= pos_nxt;
      exp_r   <= exp_nxt;
      sum_r   <= sum_nxt;
      ftype_r <= ftype_nxt;
      flen_r  <= flen_nxt;
      dbank_r <= dbank_nxt;
      dtype_r <= dtype_nxt;
      dlen_r  <= dlen_nxt;
      err_r   <= err_nxt;
    end
  end

  // result record for stage one
  always_comb begin
    s1_nxt.feed_status   = status;
    s1_nxt.error_kind    = err_nxt;
    s1_nxt.packet_type   = dtype_nxt;
    s1_nxt.packet_length = dlen_nxt;
    s1_nxt.rd_en         = mem_re;
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (out_load) begin
      out_r    <= s1_r;
      out_rd_r <= s1_r.rd_en ? mem_q_r : 8'd0;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_feed_status   = out_r.feed_status;
  assign out_error_kind    = out_r.error_kind;
  assign out_packet_type   = out_r.packet_type;
  assign out_packet_length = out_r.packet_length;
  assign out_read_data     = out_rd_r;

  // checks
  a_pos_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < exp_r)
    else $error("frame position reached expected total");

  a_dlen_fits: assert property (@(posedge clk) disable iff (!rst_n)
    dlen_r <= DEPTH8)
    else $error("delivered length exceeds buffer depth");

  a_deliver_clears_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_r.feed_status == ST_DELIVERED) |-> out_r.error_kind == ERR_NONE)
    else $error("delivered packet carries an error kind");

  a_read_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_rd_r != 8'd0) |-> out_r.feed_status == ST_NONE)
    else $error("read data on a feed result");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_vld_r && out_vld_r && !out_ready)
    else $error("request stalled with room in the pipeline");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sum8_framed_byte_parser. Drives feed and read
// requests over valid/ready: a short directed sequence of frame errors, a
// delivery and reads, then random frames, noise and reads under several
// register settings and back-pressure mixes. Each result is checked against
// an in-bench mirror of the parser state.
// ----------------------------------------------------------------------------
module testbench;
  import sfbp_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int DEPTH = DEF_PAYLOAD_DEPTH;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int RUN_LIMIT_NS = 2_000_000;
  // register index with no register behind it
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } request_t;

  typedef struct packed {
    logic [1:0] feed_status;
    logic [1:0] error_kind;
    logic [7:0] packet_type;
    logic [7:0] packet_length;
    logic [7:0] read_data;
  } parse_result_t;

  typedef enum int {FRAME_GOOD, FRAME_BAD_VERSION, FRAME_BAD_LENGTH, FRAME_BAD_SUM}
    frame_fault_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_cmd = CMD_FEED;
  logic [7:0] in_data_byte = '0;
  logic [7:0] in_read_index = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_feed_status;
  logic [1:0] out_error_kind;
  logic [7:0] out_packet_type;
  logic [7:0] out_packet_length;
  logic [7:0] out_read_data;

  sum8_framed_byte_parser DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_data_byte      (in_data_byte),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_feed_status   (out_feed_status),
    .out_error_kind    (out_error_kind),
    .out_packet_type   (out_packet_type),
    .out_packet_length (out_packet_length),
    .out_read_data     (out_read_data)
  );

  // Request and expected-result stores
  request_t      pending_reqs[$];
  parse_result_t expected_results[$];
  request_t      drive_req;
  parse_result_t seen_res;
  parse_result_t want_res;
  int reqs_open = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Register values the frame generator builds against
  logic [7:0] gen_magic = '0;
  logic [7:0] gen_version = '0;
  logic [7:0] gen_maxlen = MAXLEN_RST;

  // Parser mirror: registers, frame state, payload banks, published packet
  logic [7:0] pm_magic;
  logic [7:0] pm_version;
  logic [7:0] pm_maxlen;
  logic [8:0] pm_pos;
  logic [8:0] pm_total;
  logic [7:0] pm_sum;
  logic [7:0] pm_ftype;
  logic [7:0] pm_flen;
  logic [7:0] pm_banks [0:2*DEPTH-1];
  logic       pm_bank;
  logic [7:0] pm_pub_type;
  logic [7:0] pm_pub_len;
  logic [1:0] pm_err;

  function automatic void parser_restart();
    pm_pos = POS_MAGIC;
    pm_total = HDR_LEN;
    pm_sum = '0;
  endfunction

  function automatic void parser_reset();
    pm_magic = '0;
    pm_version = '0;
    pm_maxlen = MAXLEN_RST;
    parser_restart();
    pm_ftype = '0;
    pm_flen = '0;
    pm_bank = 1'b0;
    pm_pub_type = '0;
    pm_pub_len = '0;
    pm_err = ERR_NONE;
  endfunction

  // Advance the mirror by one request and return the result it produces
  function automatic parse_result_t parse_request(request_t rq);
    parse_result_t res;
    logic [7:0] b;
    logic [7:0] limit;
    int idx;
    res = '0;
    b = rq.data_byte;
    if (rq.cmd == CMD_FEED) begin
      res.feed_status = ST_NONE;
      case (pm_pos)
        POS_MAGIC: begin
          // idle: anything but the magic byte is dropped
          if (b == pm_magic) begin
            pm_sum = b;
            pm_pos = POS_VERSION;
          end
        end
        POS_VERSION: begin
          if (b != pm_version) begin
            parser_restart();
            pm_err = ERR_VERSION;
            res.feed_status = ST_ERROR;
          end else begin
            pm_sum += b;
            pm_pos = POS_TYPE;
          end
        end
        POS_TYPE: begin
          pm_ftype = b;
          pm_sum += b;
          pm_pos = POS_LENGTH;
        end
        POS_LENGTH: begin
          limit = (pm_maxlen < DEPTH) ? pm_maxlen : 8'(DEPTH);
          if (b > limit) begin
            parser_restart();
            pm_err = ERR_LENGTH;
            res.feed_status = ST_ERROR;
          end else begin
            pm_flen = b;
            pm_total = {1'b0, b} + FRAME_EXTRA;
            pm_sum += b;
            pm_pos = HDR_LEN;
          end
        end
        default: begin
          if (int'(pm_pos) + 1 >= int'(pm_total)) begin
            // checksum byte closes the frame
            if (pm_sum != b) begin
              parser_restart();
              pm_err = ERR_CHECKSUM;
              res.feed_status = ST_ERROR;
            end else begin
              pm_bank = ~pm_bank;
              pm_pub_type = pm_ftype;
              pm_pub_len = pm_flen;
              parser_restart();
              pm_err = ERR_NONE;
              res.feed_status = ST_DELIVERED;
            end
          end else begin
            // payload goes to the bank not being published
            idx = int'(pm_pos) - int'(HDR_LEN);
            if (idx < DEPTH)
              pm_banks[(pm_bank ? 0 : DEPTH) + idx] = b;
            pm_sum += b;
            pm_pos = pm_pos + 9'd1;
          end
        end
      endcase
    end else if (rq.read_index < pm_pub_len && rq.read_index < DEPTH) begin
      res.read_data = pm_banks[(pm_bank ? DEPTH : 0) + int'(rq.read_index)];
    end
    res.error_kind = pm_err;
    res.packet_type = pm_pub_type;
    res.packet_length = pm_pub_len;
    return res;
  endfunction

  // Request builders
  task automatic push_req(input logic cmd, input logic [7:0] data, input logic [7:0] ridx);
    pending_reqs.push_back(request_t'{cmd, data, ridx});
    reqs_open++;
  endtask

  task automatic push_feed(input logic [7:0] b);
    push_req(CMD_FEED, b, 8'($urandom_range(0, 254)));
  endtask

  task automatic push_read(input logic [7:0] ridx);
    push_req(CMD_READ, 8'($urandom), ridx);
  endtask

  // One frame, cut short where its fault makes the parser restart.
  // A negative length picks one at random, mostly short.
  task automatic push_frame(input frame_fault_t fault, input int flen);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] limit;
    int i;
    limit = (gen_maxlen < DEPTH) ? gen_maxlen : 8'(DEPTH);
    if (fault == FRAME_BAD_LENGTH && limit == 8'd255)
      fault = FRAME_BAD_SUM;
    if (flen < 0) begin
      if ($urandom_range(0, 99) < 4)
        flen = $urandom_range(0, int'(limit));
      else
        flen = $urandom_range(0, (limit < 12) ? int'(limit) : 12);
    end
    push_feed(gen_magic);
    sum = gen_magic;
    if (fault == FRAME_BAD_VERSION) begin
      push_feed(gen_version ^ 8'($urandom_range(1, 255)));
      return;
    end
    push_feed(gen_version);
    sum += gen_version;
    b = 8'($urandom);
    push_feed(b);
    sum += b;
    if (fault == FRAME_BAD_LENGTH) begin
      push_feed(8'($urandom_range(int'(limit) + 1, 255)));
      return;
    end
    push_feed(8'(flen));
    sum += 8'(flen);
    for (i = 0; i < flen; i++) begin
      b = 8'($urandom);
      push_feed(b);
      sum += b;
    end
    push_feed((fault == FRAME_BAD_SUM) ? (sum ^ 8'($urandom_range(1, 255))) : sum);
  endtask

  // Register write over the cfg channel; only called with nothing in flight
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAGIC: begin
        pm_magic = val;
        gen_magic = val;
      end
      CFG_VERSION: begin
        pm_version = val;
        gen_version = val;
      end
      CFG_MAXLEN: begin
        pm_maxlen = val;
        gen_maxlen = val;
      end
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    wait (reqs_open == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Program the registers, then queue mostly well-formed frames plus noise
  // and reads; noise bytes do not count toward the target
  task automatic run_phase(input logic [7:0] magic, input logic [7:0] ver,
                           input logic [7:0] maxlen, input int idle, input int stall,
                           input int target, input bit long_frame);
    int issued;
    int mark;
    int r;
    int k;
    write_reg(CFG_MAGIC, magic);
    write_reg(CFG_VERSION, ver);
    write_reg(CFG_MAXLEN, maxlen);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    if (long_frame) begin
      push_frame(FRAME_GOOD, 255);
      push_read(8'd0);
      push_read(8'd254);
    end
    issued = 0;
    while (issued < target) begin
      mark = reqs_open;
      r = $urandom_range(0, 99);
      if (r < 50) begin
        push_frame(FRAME_GOOD, -1);
      end else if (r < 58) begin
        push_frame(FRAME_BAD_SUM, -1);
      end else if (r < 64) begin
        push_frame(FRAME_BAD_VERSION, -1);
      end else if (r < 70) begin
        push_frame(FRAME_BAD_LENGTH, -1);
      end else if (r < 86) begin
        for (k = $urandom_range(1, 4); k > 0; k--)
          push_read($urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                         : 8'($urandom_range(0, 254)));
      end else begin
        for (k = $urandom_range(1, 3); k > 0; k--)
          push_feed(8'($urandom));
        mark = reqs_open;
      end
      issued += reqs_open - mark;
    end
    wait_idle();
  endtask

  // Clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Request driver: holds each request until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(parse_request(request_t'{in_cmd, in_data_byte,
                                                            in_read_index}));
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drive_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_cmd <= drive_req.cmd;
          in_data_byte <= drive_req.data_byte;
          in_read_index <= drive_req.read_index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen_res = '{out_feed_status, out_error_kind, out_packet_type,
                     out_packet_length, out_read_data};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] result with no request pending: status %0d err %0d",
                     $realtime, seen_res.feed_status, seen_res.error_kind);
        end else begin
          want_res = expected_results.pop_front();
          reqs_open--;
          if (seen_res.feed_status !== want_res.feed_status ||
              seen_res.error_kind !== want_res.error_kind ||
              seen_res.packet_type !== want_res.packet_type ||
              seen_res.packet_length !== want_res.packet_length ||
              seen_res.read_data !== want_res.read_data) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"[%0t] result mismatch: status %0d/%0d err %0d/%0d ",
                        "type %h/%h len %0d/%0d data %h/%h (expected/actual)"},
                       $realtime, want_res.feed_status, seen_res.feed_status,
                       want_res.error_kind, seen_res.error_kind,
                       want_res.packet_type, seen_res.packet_type,
                       want_res.packet_length, seen_res.packet_length,
                       want_res.read_data, seen_res.read_data);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Main sequence
  initial begin
    parser_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: errors of each kind, a delivery, reads in and past the packet
    write_reg(CFG_MAGIC, 8'hA5);
    write_reg(CFG_VERSION, 8'h5A);
    write_reg(CFG_MAXLEN, 8'd3);
    write_reg(CFG_SPARE, 8'hFF);
    push_read(8'd0);
    push_feed(8'h00);
    push_feed(8'hFF);
    push_frame(FRAME_BAD_VERSION, 0);
    push_frame(FRAME_BAD_LENGTH, 0);
    push_frame(FRAME_BAD_SUM, 0);
    push_frame(FRAME_GOOD, 3);
    push_read(8'd2);
    push_read(8'd3);
    push_read(8'd254);
    wait_idle();

    // Random phases over register extremes, idle mixes and stall mixes
    run_phase(8'h7E, 8'h01, 8'hFF, 0, 0, 130, 1'b1);
    run_phase(8'h00, 8'h00, 8'h00, 63, 0, 130, 1'b0);
    run_phase(8'hFF, 8'hFF, 8'h10, 0, 63, 130, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 8'($urandom_range(1, 254)), 14, 14, 130, 1'b0);

    if (mismatches == 0 && expected_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
rtl/sfbp_pkg.sv
rtl/sum8_framed_byte_parser.sv
verif/testbench.sv
